/* sv/vof_pkg.sv */
package vof_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int CHANNELS   = 3;
    localparam int CH_W       = 8;
    localparam int POS_W      = 10;
    localparam int DIM_W      = 11;
    localparam int COL_AW     = $clog2(MAX_WIDTH);
    localparam int PIX_W      = CHANNELS * CH_W;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int PADDR_W    = 3;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    // channel 0 is blue, 1 green, 2 red
    typedef logic [CHANNELS-1:0][CH_W-1:0] t_pixel;

    typedef struct packed {
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  red;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             done;
    } t_result;

    // stage 1 control flags
    typedef struct packed {
        logic first_row;
        logic second_row;
        logic last_row;
        logic done;
    } t_s1_flags;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* sv/vof_intf.sv */
interface vof_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;

    modport source (output valid, output blue_in, output green_in, output red_in,
                    input ready);
    modport sink   (input valid, input blue_in, input green_in, input red_in,
                    output ready);
endinterface

interface vof_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic [9:0] pixel_column;
    logic [9:0] pixel_row;
    logic       frame_done;

    modport source (output valid, output blue_out, output green_out, output red_out,
                    output pixel_column, output pixel_row, output frame_done,
                    input ready);
    modport sink   (input valid, input blue_out, input green_out, input red_out,
                    input pixel_column, input pixel_row, input frame_done,
                    output ready);
endinterface

/* sv/vertical_or_filter_3row_top.sv */
// result path: a pixel is registered in stage 1, then its results are written to the output queue
// throughput: one pixel per cycle while the output queue has room; in the last row each pixel
// gives two results, so the single output port throttles the input in that row
// line buffers: one 1024 x 48 ram, one read and one write per cycle
// reset: synchronous active-low, clears counters, pipeline and output queue,
// sets width and height to 1; line buffer contents are not cleared
module vertical_or_filter_3row_top
    import vof_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    vof_pix_if.sink            i_pix,
    vof_res_if.source          o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // configuration
    logic [DIM_W-1:0] r_width, r_height;
    logic [DIM_W-1:0] r_w_eff, r_h_eff;
    logic             cfg_wr;
    t_reg_idx         reg_idx;

    // position counters
    logic [POS_W-1:0] r_col, r_row;
    logic [POS_W-1:0] n_col, n_row;

    // stage 1
    logic             r_s1_valid;
    t_pixel           r_s1_px;
    logic [POS_W-1:0] r_s1_col, r_s1_row;
    t_s1_flags        r_s1_flags;
    logic             r_byp;
    logic [2*PIX_W-1:0] r_byp_data;

    logic [2*PIX_W-1:0] ram_q, line_q, ram_wdata;
    t_pixel           above, centre, filt;

    // output queue
    t_result          r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_head, r_tail;
    logic [FIFO_AW:0] r_cnt;
    logic [1:0]       push_n;
    t_result          push0, push1;

    logic             in_fire, out_fire, last_row, frame_end;
    logic [FIFO_AW+1:0] need;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, r_width};
            REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, r_height};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_w_eff  <= DIM_W'(1);
            r_h_eff  <= DIM_W'(1);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_WIDTH: begin
                    r_width <= pwdata[DIM_W-1:0];
                    r_w_eff <= clamp_dim(pwdata[DIM_W-1:0], DIM_W'(MAX_WIDTH));
                end
                REG_HEIGHT: begin
                    r_height <= pwdata[DIM_W-1:0];
                    r_h_eff  <= clamp_dim(pwdata[DIM_W-1:0], DIM_W'(MAX_HEIGHT));
                end
                default: begin
                end
            endcase
        end
    end

    // room for two results from stage 1 and two from the new pixel
    assign need        = (FIFO_AW+2)'(r_cnt) + (r_s1_valid ? (FIFO_AW+2)'(2) : '0)
                         + (FIFO_AW+2)'(2);
    assign i_pix.ready = (need <= (FIFO_AW+2)'(FIFO_DEPTH));
    assign in_fire     = i_pix.valid && i_pix.ready;

    assign last_row  = ({1'b0, r_row} + DIM_W'(1)) >= r_h_eff;
    assign frame_end = ({1'b0, r_col} + DIM_W'(1)) >= r_w_eff;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_fire) begin
            if (frame_end) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + POS_W'(1);
            end else begin
                n_col = r_col + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage 0 -> stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_byp      <= 1'b0;
        end else begin
            r_s1_valid <= in_fire;
            r_byp      <= in_fire && r_s1_valid && (r_s1_col == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_px                <= {i_pix.red_in, i_pix.green_in, i_pix.blue_in};
            r_s1_col               <= r_col;
            r_s1_row               <= r_row;
            r_s1_flags.first_row   <= (r_row == '0);
            r_s1_flags.second_row  <= (r_row == POS_W'(1));
            r_s1_flags.last_row    <= last_row;
            r_s1_flags.done        <= last_row && frame_end;
        end
        r_byp_data <= ram_wdata;
    end

    // entry holds {row y-1, row y-2}; forward the write when width is one
    vof_ram #(
        .WIDTH (2*PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col[COL_AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (r_col[COL_AW-1:0]),
        .o_rdata (ram_q)
    );

    assign line_q    = r_byp ? r_byp_data : ram_q;
    assign above     = t_pixel'(line_q[PIX_W-1:0]);
    assign centre    = t_pixel'(line_q[2*PIX_W-1:PIX_W]);
    assign ram_wdata = {r_s1_px, centre};

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        vof_lane u_lane (
            .i_above  (above[c]),
            .i_centre (centre[c]),
            .i_below  (r_s1_px[c]),
            .o_filt   (filt[c])
        );
    end

    // merge lanes into results
    always_comb begin
        push_n = 2'd0;
        push0  = '{blue: r_s1_px[0], green: r_s1_px[1], red: r_s1_px[2],
                   col: r_s1_col, row: r_s1_row, done: r_s1_flags.done};
        push1  = push0;
        if (r_s1_valid) begin
            if (r_s1_flags.first_row) begin
                push_n = 2'd1;
            end else if (r_s1_flags.second_row) begin
                push_n = r_s1_flags.last_row ? 2'd1 : 2'd0;
            end else begin
                push0  = '{blue: filt[0], green: filt[1], red: filt[2],
                           col: r_s1_col, row: r_s1_row - POS_W'(1), done: 1'b0};
                push_n = r_s1_flags.last_row ? 2'd2 : 2'd1;
            end
        end
    end

    assign out_fire = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_fifo[r_tail] <= push0;
        end
        if (push_n == 2'd2) begin
            r_fifo[r_tail + FIFO_AW'(1)] <= push1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_tail <= r_tail + FIFO_AW'(push_n);
            r_head <= r_head + (out_fire ? FIFO_AW'(1) : '0);
            r_cnt  <= r_cnt + (FIFO_AW+1)'(push_n) - (out_fire ? (FIFO_AW+1)'(1) : '0);
        end
    end

    assign o_res.valid        = (r_cnt != '0);
    assign o_res.blue_out     = r_fifo[r_head].blue;
    assign o_res.green_out    = r_fifo[r_head].green;
    assign o_res.red_out      = r_fifo[r_head].red;
    assign o_res.pixel_column = r_fifo[r_head].col;
    assign o_res.pixel_row    = r_fifo[r_head].row;
    assign o_res.frame_done   = r_fifo[r_head].done;

`ifndef NO_ASSERTIONS
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("output queue overflow");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_col} < r_w_eff)
        else $error("column counter beyond width");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_row} < r_h_eff)
        else $error("row counter beyond height");

    a_bypass_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp |-> r_s1_valid && $past(r_s1_valid))
        else $error("forwarding without a write in flight");
`endif

endmodule

/* sv/vof_ram.sv */
module vof_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/vof_lane.sv */
module vof_lane
    import vof_pkg::*;
(
    input  logic [CH_W-1:0] i_above,
    input  logic [CH_W-1:0] i_centre,
    input  logic [CH_W-1:0] i_below,
    output logic [CH_W-1:0] o_filt
);

    // vertical three-tap bitwise OR of one channel
    assign o_filt = i_above | i_centre | i_below;

endmodule
